/* src/uts_pkg.sv */
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types, codes and mapping functions of the UTF-8 text sanitizer.
// ----------------------------------------------------------------------------
package uts_pkg;

  localparam int UTS_MAX_OUT     = 3;
  localparam int UTS_QUEUE_DEPTH = 2;

  localparam logic [7:0] LEAD_HEBREW  = 8'hD7;
  localparam logic [7:0] LEAD_LATIN_A = 8'hC2;
  localparam logic [7:0] LEAD_LATIN_B = 8'hC3;
  localparam logic [7:0] LEAD_PUNCT   = 8'hE2;
  localparam logic [7:0] PUNCT_MID    = 8'h80;

  localparam logic [7:0] HEB_LO       = 8'h90;
  localparam logic [7:0] HEB_HI       = 8'hAA;
  localparam logic [7:0] NBSP_LO      = 8'hA0;
  localparam logic [7:0] GUIL_LEFT    = 8'hAB;
  localparam logic [7:0] GUIL_RIGHT   = 8'hBB;
  localparam logic [7:0] ELLIPSIS_LO  = 8'hA6;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;

  localparam logic [1:0] HOLD_NONE    = 2'd0;
  localparam logic [1:0] HOLD_LEAD    = 2'd1;
  localparam logic [1:0] HOLD_PAIR    = 2'd2;

  typedef struct packed {
    logic [1:0]                   count;
    logic [UTS_MAX_OUT-1:0][7:0]  chars;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_lead(input logic [7:0] c);
    return c == LEAD_HEBREW || c == LEAD_LATIN_A || c == LEAD_LATIN_B || c == LEAD_PUNCT;
  endfunction

  function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic job_t one_char(input logic [7:0] c);
    job_t j;
    j          = '0;
    j.count    = 2'd1;
    j.chars[0] = c;
    return j;
  endfunction

  function automatic job_t plain_job(input logic [7:0] c);
    job_t j;
    j = '0;
    if (in_rng(c, CH_SPACE, CH_TILDE) || c == CH_LF) begin
      j = one_char(c);
    end else if (c == CH_TAB) begin
      j.count    = 2'd2;
      j.chars[0] = CH_SPACE;
      j.chars[1] = CH_SPACE;
    end
    return j;
  endfunction

  function automatic job_t pair_job(input logic [7:0] lead, input logic [7:0] c);
    job_t j;
    j = '0;
    if (lead == LEAD_HEBREW) begin
      if (in_rng(c, HEB_LO, HEB_HI)) begin
        j.count    = 2'd2;
        j.chars[0] = lead;
        j.chars[1] = c;
      end
    end else if (lead == LEAD_LATIN_A) begin
      if (c == NBSP_LO) j = one_char(CH_SPACE);
      else if (c == GUIL_LEFT || c == GUIL_RIGHT) j = one_char(CH_DQUOTE);
    end else if (lead == LEAD_LATIN_B) begin
      if (in_rng(c, 8'h80, 8'h85)) j = one_char("A");
      else if (in_rng(c, 8'hA0, 8'hA5)) j = one_char("a");
      else if (in_rng(c, 8'h88, 8'h8B)) j = one_char("E");
      else if (in_rng(c, 8'hA8, 8'hAB)) j = one_char("e");
      else if (in_rng(c, 8'h8C, 8'h8F)) j = one_char("I");
      else if (in_rng(c, 8'hAC, 8'hAF)) j = one_char("i");
      else if (in_rng(c, 8'h92, 8'h96)) j = one_char("O");
      else if (in_rng(c, 8'hB2, 8'hB6)) j = one_char("o");
      else if (in_rng(c, 8'h99, 8'h9C)) j = one_char("U");
      else if (in_rng(c, 8'hB9, 8'hBC)) j = one_char("u");
    end
    return j;
  endfunction

  function automatic job_t triple_job(input logic [7:0] c);
    job_t j;
    j = '0;
    if (c == 8'h98 || c == 8'h99) j = one_char(CH_SQUOTE);
    else if (c == 8'h9C || c == 8'h9D) j = one_char(CH_DQUOTE);
    else if (c == 8'h93 || c == 8'h94) j = one_char(CH_DASH);
    else if (c == ELLIPSIS_LO) begin
      j.count    = 2'd3;
      j.chars[0] = CH_DOT;
      j.chars[1] = CH_DOT;
      j.chars[2] = CH_DOT;
    end
    return j;
  endfunction

endpackage

/* src/uts_if.sv */
// ----------------------------------------------------------------------------
// uts_if
// Valid/ready channels for raw input bytes and cleaned output bytes.
// ----------------------------------------------------------------------------
interface uts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface uts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* src/uts_front.sv */
// ----------------------------------------------------------------------------
// uts_front
// Accepts input beats, tracks held lead bytes and classifies each byte into
// a job of zero to three output characters.
// ----------------------------------------------------------------------------
module uts_front
  import uts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  uts_in_if.sink  in_bytes,
  input  q_stat_t q_stat,
  output logic    push,
  output job_t    push_job
);

  logic [7:0] held_first, held_first_next;
  logic [1:0] held_count, held_count_next;
  logic       accept;
  logic       use_plain;
  job_t       job;
  job_t       pj;
  job_t       tj;

  assign in_bytes.ready = !q_stat.full;
  assign accept         = in_bytes.valid && in_bytes.ready;

  always_comb begin
    job             = '0;
    held_first_next = held_first;
    held_count_next = HOLD_NONE;
    use_plain       = 1'b0;
    pj              = pair_job(held_first, in_bytes.in_byte);
    tj              = triple_job(in_bytes.in_byte);
    case (held_count)
      HOLD_LEAD: begin
        if (held_first == LEAD_PUNCT) begin
          if (in_bytes.in_byte == PUNCT_MID && !in_bytes.end_of_text) begin
            held_count_next = HOLD_PAIR;
          end else begin
            use_plain = 1'b1;
          end
        end else if (pj.count != 2'd0) begin
          job = pj;
        end else begin
          use_plain = 1'b1;
        end
      end
      HOLD_PAIR: begin
        if (tj.count != 2'd0) job = tj;
        else use_plain = 1'b1;
      end
      default: use_plain = 1'b1;
    endcase
    if (use_plain) begin
      if (is_lead(in_bytes.in_byte)) begin
        held_first_next = in_bytes.in_byte;
        held_count_next = HOLD_LEAD;
      end else begin
        job = plain_job(in_bytes.in_byte);
      end
    end
    if (in_bytes.end_of_text) held_count_next = HOLD_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HOLD_NONE;
      held_first <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_first <= held_first_next;
    end
  end

  assign push     = accept && (job.count != 2'd0);
  assign push_job = job;

endmodule

/* src/uts_queue.sv */
// ----------------------------------------------------------------------------
// uts_queue
// Short job queue between classifier and emitter.
// ----------------------------------------------------------------------------
module uts_queue
  import uts_pkg::*;
#(
  parameter int DEPTH = UTS_QUEUE_DEPTH
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

/* src/uts_back.sv */
// ----------------------------------------------------------------------------
// uts_back
// Emits the characters of each queued job, one beat per cycle while the
// output is ready, through an output register.
// ----------------------------------------------------------------------------
module uts_back
  import uts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  uts_out_if.source out_chars
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = (!out_chars.valid || out_chars.ready) && !q_stat.empty;
  assign is_last = (idx == head.count - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chars.valid <= 1'b0;
      idx             <= '0;
    end else begin
      if (load) begin
        out_chars.valid <= 1'b1;
        idx             <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_chars.ready) begin
        out_chars.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_chars.out_char <= head.chars[idx];
      out_chars.run_last <= is_last;
    end
  end

endmodule

/* src/utf8_text_sanitizer_top.sv */
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top
// Streaming UTF-8 clean-up filter: maps known multi-byte sequences to ASCII,
// passes Hebrew letters and LF, expands tabs, drops other unprintable bytes.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the job queue has room; a byte
// that expands to two or three characters (tab, Hebrew letter, ellipsis)
// takes one output beat per character, and the input stalls once the
// queue of QUEUE_DEPTH jobs fills. Bytes that produce nothing never occupy
// the output. An input beat's job is registered in the queue, and its first
// character then in the output register.
module utf8_text_sanitizer_top
  import uts_pkg::*;
#(
  parameter int QUEUE_DEPTH = UTS_QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst,
  uts_in_if.sink     in_bytes,
  uts_out_if.source  out_chars
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;

  uts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  uts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  uts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_chars (out_chars)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> push_job.count != 2'd0 && push_job.count <= 2'd3)
    else $error("empty job queued");

  a_pop_last_beat: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_chars.valid && out_chars.run_last)
    else $error("job retired without last beat");

endmodule

/* tb/utf8_text_sanitizer_top_tb.sv */
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top_tb
// Self-checking bench for the UTF-8 text sanitizer. A scoreboard class keeps
// its own copy of the held-byte state and predicts the cleaned characters of
// every accepted input beat. Each output beat is checked against the oldest
// prediction. The stimulus starts with hand-picked sequences and then sends
// random texts built from multi-byte sequences and printable ASCII, with
// control bytes, broken sequences, noise and truncated endings mixed in. Both
// channels idle at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer_top_tb;
  import uts_pkg::*;

  localparam int TARGET_BYTES = 400;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int IDLE_PCT     = 28;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } clean_beat_t;

  class char_board;
    logic [7:0]  held_lead;
    logic [7:0]  held_mid;
    logic [1:0]  held_n;
    clean_beat_t awaited[$];
    logic [7:0]  staged[$];
    int          errors;
    int          checked;
    int          taken;
    int          active;

    function new();
      held_lead = '0;
      held_mid  = '0;
      held_n    = HOLD_NONE;
      errors    = 0;
      checked   = 0;
      taken     = 0;
      active    = 0;
    endfunction

    function void stage(logic [7:0] c);
      staged.insert(staged.size(), c);
    endfunction

    function bit starts_sequence(logic [7:0] c);
      return c == LEAD_HEBREW || c == LEAD_LATIN_A || c == LEAD_LATIN_B ||
             c == LEAD_PUNCT;
    endfunction

    function void emit_plain(logic [7:0] c);
      if (starts_sequence(c)) begin
        held_lead = c;
        held_mid  = '0;
        held_n    = HOLD_LEAD;
      end else if ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_LF) begin
        stage(c);
      end else if (c == CH_TAB) begin
        stage(CH_SPACE);
        stage(CH_SPACE);
      end
    endfunction

    function bit emit_pair(logic [7:0] lead, logic [7:0] c);
      logic [7:0] ch;
      ch = '0;
      if (lead == LEAD_HEBREW) begin
        if (c >= HEB_LO && c <= HEB_HI) begin
          stage(lead);
          stage(c);
          return 1'b1;
        end
        return 1'b0;
      end
      if (lead == LEAD_LATIN_A) begin
        if (c == NBSP_LO) ch = CH_SPACE;
        else if (c == GUIL_LEFT || c == GUIL_RIGHT) ch = CH_DQUOTE;
      end else if (lead == LEAD_LATIN_B) begin
        if (c >= 8'h80 && c <= 8'h85) ch = "A";
        else if (c >= 8'hA0 && c <= 8'hA5) ch = "a";
        else if (c >= 8'h88 && c <= 8'h8B) ch = "E";
        else if (c >= 8'hA8 && c <= 8'hAB) ch = "e";
        else if (c >= 8'h8C && c <= 8'h8F) ch = "I";
        else if (c >= 8'hAC && c <= 8'hAF) ch = "i";
        else if (c >= 8'h92 && c <= 8'h96) ch = "O";
        else if (c >= 8'hB2 && c <= 8'hB6) ch = "o";
        else if (c >= 8'h99 && c <= 8'h9C) ch = "U";
        else if (c >= 8'hB9 && c <= 8'hBC) ch = "u";
      end
      if (ch == 8'h00) return 1'b0;
      stage(ch);
      return 1'b1;
    endfunction

    function bit emit_triple(logic [7:0] c);
      if (c == 8'h98 || c == 8'h99) stage(CH_SQUOTE);
      else if (c == 8'h9C || c == 8'h9D) stage(CH_DQUOTE);
      else if (c == 8'h93 || c == 8'h94) stage(CH_DASH);
      else if (c == ELLIPSIS_LO) begin
        stage(CH_DOT);
        stage(CH_DOT);
        stage(CH_DOT);
      end else return 1'b0;
      return 1'b1;
    endfunction

    function void note_input(logic [7:0] b, logic eot);
      logic [7:0] lead;
      logic [1:0] n;
      lead      = held_lead;
      n         = held_n;
      held_lead = '0;
      held_mid  = '0;
      held_n    = HOLD_NONE;
      staged.delete();
      taken++;
      if (n == HOLD_LEAD) begin
        if (lead == LEAD_PUNCT) begin
          if (b == PUNCT_MID && !eot) begin
            held_lead = lead;
            held_mid  = b;
            held_n    = HOLD_PAIR;
          end else begin
            emit_plain(b);
          end
        end else if (!emit_pair(lead, b)) begin
          emit_plain(b);
        end
      end else if (n == HOLD_PAIR) begin
        if (!emit_triple(b)) emit_plain(b);
      end else begin
        emit_plain(b);
      end
      if (eot) begin
        held_lead = '0;
        held_mid  = '0;
        held_n    = HOLD_NONE;
      end
      if (staged.size() > 0 || n != HOLD_NONE || held_n != HOLD_NONE) active++;
      foreach (staged[i])
        awaited.insert(awaited.size(), clean_beat_t'{staged[i], i == staged.size() - 1});
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH %s", msg);
    endtask

    task check_result(logic [7:0] ch, logic last);
      clean_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected char %02h last %0b", ch, last));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (ch !== want.ch)
        report($sformatf("char %02h, want %02h (beat %0d)", ch, want.ch, checked));
      if (last !== want.last)
        report($sformatf("run_last %0b, want %0b (beat %0d)", last, want.last, checked));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady;
  int   cycles;
  int   texts;

  uts_in_if  in_bytes();
  uts_out_if out_chars();
  char_board sb;

  utf8_text_sanitizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_bytes  (in_bytes),
    .out_chars (out_chars)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chars.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (out_chars.valid && out_chars.ready)
        sb.check_result(out_chars.out_char, out_chars.run_last);
      if (in_bytes.valid && in_bytes.ready)
        sb.note_input(in_bytes.in_byte, in_bytes.end_of_text);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eot);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bytes.valid <= 1'b0;
      @(negedge clk);
    end
    in_bytes.valid       <= 1'b1;
    in_bytes.in_byte     <= b;
    in_bytes.end_of_text <= eot;
    do @(posedge clk); while (!in_bytes.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    foreach (text[i]) push_byte(text[i], i == text.size() - 1);
    texts++;
  endtask

  task automatic random_text();
    logic [7:0] text[$];
    logic [7:0] punct_tail[7];
    logic [7:0] latin_a_tail[3];
    int         tokens;
    int         pick;
    punct_tail   = '{8'h98, 8'h99, 8'h9C, 8'h9D, 8'h93, 8'h94, ELLIPSIS_LO};
    latin_a_tail = '{NBSP_LO, GUIL_LEFT, GUIL_RIGHT};
    tokens = $urandom_range(12, 1);
    repeat (tokens) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        text.insert(text.size(), LEAD_HEBREW);
        text.insert(text.size(), 8'($urandom_range(HEB_HI, HEB_LO)));
      end else if (pick < 20) begin
        text.insert(text.size(), LEAD_LATIN_A);
        text.insert(text.size(), latin_a_tail[$urandom_range(2)]);
      end else if (pick < 32) begin
        text.insert(text.size(), LEAD_LATIN_B);
        text.insert(text.size(), 8'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 47) begin
        text.insert(text.size(), LEAD_PUNCT);
        text.insert(text.size(), PUNCT_MID);
        text.insert(text.size(), punct_tail[$urandom_range(6)]);
      end else if (pick < 67) begin
        text.insert(text.size(), 8'($urandom_range(CH_TILDE, CH_SPACE)));
      end else if (pick < 74) begin
        pick = $urandom_range(2);
        text.insert(text.size(), pick == 0 ? CH_LF : (pick == 1 ? CH_TAB : 8'h0D));
      end else if (pick < 87) begin
        pick = $urandom_range(3);
        text.insert(text.size(), pick == 0 ? LEAD_HEBREW : pick == 1 ? LEAD_LATIN_A :
                                 pick == 2 ? LEAD_LATIN_B : LEAD_PUNCT);
        if ($urandom_range(1)) text.insert(text.size(), PUNCT_MID);
        text.insert(text.size(), 8'($urandom_range(255)));
      end else begin
        text.insert(text.size(), 8'($urandom_range(255)));
      end
    end
    // cut the text short so it can end inside a held sequence
    if (text.size() > 1 && $urandom_range(99) < 20) void'(text.pop_back());
    send_text(text);
  endtask

  initial begin
    int waited;
    sb                   = new();
    rst                  = 1'b1;
    steady               = 1'b0;
    cycles               = 0;
    texts                = 0;
    in_bytes.valid       = 1'b0;
    in_bytes.in_byte     = '0;
    in_bytes.end_of_text = 1'b0;
    out_chars.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text('{CH_SPACE, CH_TILDE, 8'h7F, CH_LF, CH_TAB, 8'h0D, 8'hFF,
                LEAD_HEBREW, HEB_LO, LEAD_HEBREW, HEB_HI, LEAD_HEBREW, 8'h8F,
                LEAD_LATIN_A, NBSP_LO, LEAD_LATIN_B, LEAD_LATIN_B, 8'hA9,
                LEAD_PUNCT, PUNCT_MID, ELLIPSIS_LO, LEAD_PUNCT, PUNCT_MID, 8'h99,
                LEAD_PUNCT, 8'h41, 8'hC5, LEAD_PUNCT, PUNCT_MID});

    while (sb.taken < TARGET_BYTES) begin
      steady = (sb.taken >= 150 && sb.taken < 230);
      random_text();
    end
    steady = 1'b0;
    in_bytes.valid <= 1'b0;

    waited = 0;
    while (sb.awaited.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.awaited.size() > 0)
      sb.report($sformatf("%0d cleaned chars never arrived", sb.awaited.size()));

    $display("sent %0d bytes in %0d texts (%0d not simply dropped)",
             sb.taken, texts, sb.active);
    $display("checked %0d cleaned chars, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
